/* rtl/bhd_pkg.sv */
package bhd_pkg;

    // Field widths of the words on the channels.
    localparam int NODE_W = 10;
    localparam int HOP_W  = 10;
    localparam int STAT_W = 2;
    localparam int MODE_W = 2;
    localparam int CFG_W  = 11;

    // Largest hop count that can be reported.
    localparam logic [HOP_W-1:0] HOP_MAX = '1;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

    // Response status codes.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_RD_WAIT,
        ST_CLR,
        ST_SEED,
        ST_POP,
        ST_POP_W,
        ST_ROW1,
        ST_ROW2,
        ST_EDGE_RD,
        ST_EDGE_NB,
        ST_EDGE_VIS
    } state_t;

    // One response word as it travels into the output queue.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [HOP_W-1:0]  distance;
    } rsp_t;

endpackage

/* rtl/bhd_in_if.sv */
interface bhd_in_if;
    import bhd_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] neighbour;

    modport source (output valid, output mode, output node, output neighbour, input ready);
    modport sink (input valid, input mode, input node, input neighbour, output ready);
endinterface

/* rtl/bhd_out_if.sv */
interface bhd_out_if;
    import bhd_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [HOP_W-1:0]  distance;

    modport source (output valid, output status, output distance, input ready);
    modport sink (input valid, input status, input distance, output ready);
endinterface

/* rtl/bhd_ram.sv */
module bhd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/bhd_out_queue.sv */
module bhd_out_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bhd_pkg::rsp_t push_word,
    output logic          room,
    bhd_out_if.source     rsp
);
    import bhd_pkg::*;

    rsp_t       q0_reg, q0_next;
    rsp_t       q1_reg, q1_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign rsp.valid    = (count_reg != 2'd0);
    assign rsp.status   = q0_reg.status;
    assign rsp.distance = q0_reg.distance;
    assign pop          = rsp.valid & rsp.ready;
    assign room         = (count_reg != 2'd2);

    // Two-entry queue so a finished word can wait while the next request runs.
    always_comb
    begin
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        count_next = count_reg;
        case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    q0_next = push_word;
                end
                else
                begin
                    q1_next = push_word;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                q0_next    = q1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    q0_next = push_word;
                end
                else
                begin
                    q0_next = q1_reg;
                    q1_next = push_word;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    // The queue never holds more than two words.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("output queue count out of range");

    // A push into a full queue would lose a word.
    assert property (@(posedge clk) disable iff (!rst_n) (push && !pop) |-> room)
        else $error("push into full output queue");

    // A word that waits on a stalled receiver stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(q0_reg)))
        else $error("stalled output word changed");

endmodule

/* rtl/bfs_hop_distance.sv */
// Breadth-first hop distances over a directed graph in compressed rows.
// Requests arrive on req (mode, node, neighbour); every request gives exactly
// one word on rsp (status, distance). cfg_we/cfg_wdata set the node count,
// clamped to 1..MAX_NODES; write it only while the block is idle.
// Clear, a rejected request and a load to the current source push their
// word straight from idle. A read makes one registered read of the hop
// store. A load to a new source writes one row start per node after the
// last source up to and including the new one. A run first sweeps the hop
// store, then seeds the queue and walks: per dequeued node a queue read,
// hop and row start reads and the end of row; per edge an edge read, plus a
// hop store check for an in-range node. The edge list, hop store and node
// queue each have one write port and one registered read.
// The block takes one request at a time; req.ready is high when idle and
// the two-entry output queue has room, so one word may wait on a stalled
// receiver while the next request is taken.
// After reset the hop store is swept to zero before the first request is
// taken; configuration writes are taken throughout.
module bfs_hop_distance #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 8192
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [bhd_pkg::CFG_W-1:0]  cfg_wdata,
    bhd_in_if.sink                     req,
    bhd_out_if.source                  rsp
);
    import bhd_pkg::*;

    localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NIW = $clog2(MAX_NODES + 1);
    localparam int RAW = $clog2(MAX_NODES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETW = $clog2(MAX_EDGES + 1);
    localparam int VW  = HOP_W + 1;

    state_t            state_reg, state_next;
    logic [NIW-1:0]    nc_reg, nc_next;
    logic [NODE_W-1:0] last_reg, last_next;
    logic [ETW-1:0]    et_reg, et_next;
    logic [NODE_W-1:0] src_reg, src_next;
    logic [NODE_W-1:0] dst_reg, dst_next;
    logic [NODE_W-1:0] fill_reg, fill_next;
    logic              run_pend_reg, run_pend_next;
    logic [NIW-1:0]    clr_reg, clr_next;
    logic [NIW-1:0]    head_reg, head_next;
    logic [NIW-1:0]    tail_reg, tail_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [HOP_W-1:0]  hop_reg, hop_next;
    logic [ETW-1:0]    e_reg, e_next;
    logic [ETW-1:0]    end_reg, end_next;
    logic [NODE_W-1:0] nb_reg, nb_next;

    // Memory ports.
    logic              edge_we;
    logic [EAW-1:0]    edge_waddr, edge_raddr;
    logic [NODE_W-1:0] edge_wdata, edge_rdata;
    logic              row_we;
    logic [RAW-1:0]    row_waddr, row_raddr;
    logic [ETW-1:0]    row_wdata, row_rdata;
    logic              vis_we;
    logic [NAW-1:0]    vis_waddr, vis_raddr;
    logic [VW-1:0]     vis_wdata, vis_rdata;
    logic              fifo_we;
    logic [NAW-1:0]    fifo_waddr, fifo_raddr;
    logic [NODE_W-1:0] fifo_wdata, fifo_rdata;

    logic              push;
    rsp_t              push_word;
    logic              room;

    // Request decode shared by both control blocks.
    logic              accept;
    logic              node_ok, nb_ok, load_bad, store_full, new_node_ok;
    logic [31:0]       cfg_val;

    assign accept      = req.valid & req.ready;
    assign req.ready   = (state_reg == ST_IDLE) && room;
    assign node_ok     = 32'(req.node) < 32'(nc_reg);
    assign nb_ok       = 32'(req.neighbour) < 32'(nc_reg);
    assign load_bad    = !node_ok || !nb_ok || (req.node < last_reg);
    assign store_full  = (et_reg == ETW'(MAX_EDGES));
    assign new_node_ok = 32'(edge_rdata) < 32'(nc_reg);
    assign cfg_val     = 32'(cfg_wdata);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.mode)
                        MODE_LOAD:
                        begin
                            if (!load_bad && !store_full && (req.node != last_reg))
                            begin
                                state_next = ST_FILL;
                            end
                        end
                        MODE_RUN:
                        begin
                            if (node_ok)
                            begin
                                state_next = ST_CLR;
                            end
                        end
                        MODE_READ:
                        begin
                            if (node_ok)
                            begin
                                state_next = ST_RD_WAIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                if (fill_reg == src_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_WAIT:
            begin
                state_next = ST_IDLE;
            end
            ST_CLR:
            begin
                if (clr_reg == NIW'(MAX_NODES - 1))
                begin
                    state_next = run_pend_reg ? ST_SEED : ST_IDLE;
                end
            end
            ST_SEED:
            begin
                state_next = ST_POP;
            end
            ST_POP:
            begin
                state_next = (head_reg == tail_reg) ? ST_IDLE : ST_POP_W;
            end
            ST_POP_W:
            begin
                state_next = ST_ROW1;
            end
            ST_ROW1:
            begin
                state_next = ST_ROW2;
            end
            ST_ROW2:
            begin
                state_next = ST_EDGE_RD;
            end
            ST_EDGE_RD:
            begin
                state_next = (e_reg < end_reg) ? ST_EDGE_NB : ST_POP;
            end
            ST_EDGE_NB:
            begin
                state_next = new_node_ok ? ST_EDGE_VIS : ST_EDGE_RD;
            end
            ST_EDGE_VIS:
            begin
                state_next = ST_EDGE_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and responses.
    always_comb
    begin
        nc_next       = nc_reg;
        last_next     = last_reg;
        et_next       = et_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        fill_next     = fill_reg;
        run_pend_next = run_pend_reg;
        clr_next      = clr_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        cur_next      = cur_reg;
        hop_next      = hop_reg;
        e_next        = e_reg;
        end_next      = end_reg;
        nb_next       = nb_reg;

        edge_we       = 1'b0;
        edge_waddr    = EAW'(et_reg);
        edge_wdata    = dst_reg;
        edge_raddr    = EAW'(e_reg);
        row_we        = 1'b0;
        row_waddr     = RAW'(fill_reg);
        row_wdata     = et_reg;
        row_raddr     = RAW'(cur_reg);
        vis_we        = 1'b0;
        vis_waddr     = clr_reg[NAW-1:0];
        vis_wdata     = '0;
        vis_raddr     = NAW'(cur_reg);
        fifo_we       = 1'b0;
        fifo_waddr    = tail_reg[NAW-1:0];
        fifo_wdata    = nb_reg;
        fifo_raddr    = head_reg[NAW-1:0];

        push          = 1'b0;
        push_word     = '{status: STAT_OK, distance: '0};

        // Node count register, clamped to the legal range.
        if (cfg_we)
        begin
            if (cfg_val == 32'd0)
            begin
                nc_next = NIW'(1);
            end
            else if (cfg_val > 32'(MAX_NODES))
            begin
                nc_next = NIW'(MAX_NODES);
            end
            else
            begin
                nc_next = NIW'(cfg_val);
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                vis_raddr = NAW'(req.node);
                if (accept)
                begin
                    src_next = req.node;
                    dst_next = req.neighbour;
                    case (req.mode)
                        MODE_LOAD:
                        begin
                            if (load_bad)
                            begin
                                push             = 1'b1;
                                push_word.status = STAT_RANGE;
                            end
                            else if (store_full)
                            begin
                                push             = 1'b1;
                                push_word.status = STAT_FULL;
                            end
                            else if (req.node == last_reg)
                            begin
                                edge_we    = 1'b1;
                                edge_wdata = req.neighbour;
                                et_next    = et_reg + ETW'(1);
                                push       = 1'b1;
                            end
                            else
                            begin
                                fill_next = last_reg + NODE_W'(1);
                            end
                        end
                        MODE_RUN:
                        begin
                            if (node_ok)
                            begin
                                run_pend_next = 1'b1;
                                clr_next      = '0;
                            end
                            else
                            begin
                                push             = 1'b1;
                                push_word.status = STAT_RANGE;
                            end
                        end
                        MODE_READ:
                        begin
                            if (!node_ok)
                            begin
                                push             = 1'b1;
                                push_word.status = STAT_RANGE;
                            end
                        end
                        default:
                        begin
                            last_next = '0;
                            et_next   = '0;
                            push      = 1'b1;
                        end
                    endcase
                end
            end
            // Row starts for every node up to the new source.
            ST_FILL:
            begin
                row_we    = 1'b1;
                fill_next = fill_reg + NODE_W'(1);
                if (fill_reg == src_reg)
                begin
                    edge_we   = 1'b1;
                    et_next   = et_reg + ETW'(1);
                    last_next = src_reg;
                    push      = 1'b1;
                end
            end
            ST_RD_WAIT:
            begin
                push               = 1'b1;
                push_word.distance = vis_rdata[HOP_W-1:0];
            end
            // Sweep the hop store to unvisited, distance zero.
            ST_CLR:
            begin
                vis_we   = 1'b1;
                clr_next = clr_reg + NIW'(1);
            end
            ST_SEED:
            begin
                vis_we        = 1'b1;
                vis_waddr     = NAW'(src_reg);
                vis_wdata     = {1'b1, HOP_W'(0)};
                fifo_we       = 1'b1;
                fifo_waddr    = '0;
                fifo_wdata    = src_reg;
                head_next     = '0;
                tail_next     = NIW'(1);
                run_pend_next = 1'b0;
            end
            ST_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    push = 1'b1;
                end
                else
                begin
                    head_next = head_reg + NIW'(1);
                end
            end
            // Dequeued node: fetch its hop count and row start.
            ST_POP_W:
            begin
                cur_next  = fifo_rdata;
                vis_raddr = NAW'(fifo_rdata);
                row_raddr = RAW'(fifo_rdata);
            end
            ST_ROW1:
            begin
                row_raddr = RAW'(cur_reg) + RAW'(1);
                hop_next  = (vis_rdata[HOP_W-1:0] < HOP_MAX) ?
                            vis_rdata[HOP_W-1:0] + HOP_W'(1) : HOP_MAX;
                if (cur_reg > last_reg)
                begin
                    e_next = et_reg;
                end
                else if (cur_reg == '0)
                begin
                    e_next = '0;
                end
                else
                begin
                    e_next = row_rdata;
                end
            end
            ST_ROW2:
            begin
                end_next = (cur_reg < last_reg) ? row_rdata : et_reg;
            end
            ST_EDGE_RD:
            begin
                if (e_reg < end_reg)
                begin
                    e_next = e_reg + ETW'(1);
                end
            end
            ST_EDGE_NB:
            begin
                nb_next   = edge_rdata;
                vis_raddr = NAW'(edge_rdata);
            end
            // Mark a newly reached node and queue it.
            ST_EDGE_VIS:
            begin
                if (!vis_rdata[HOP_W])
                begin
                    vis_we    = 1'b1;
                    vis_waddr = NAW'(nb_reg);
                    vis_wdata = {1'b1, hop_reg};
                    if (tail_reg < NIW'(MAX_NODES))
                    begin
                        fifo_we   = 1'b1;
                        tail_next = tail_reg + NIW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLR;
            nc_reg       <= NIW'(MAX_NODES);
            last_reg     <= '0;
            et_reg       <= '0;
            run_pend_reg <= 1'b0;
            clr_reg      <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            nc_reg       <= nc_next;
            last_reg     <= last_next;
            et_reg       <= et_next;
            run_pend_reg <= run_pend_next;
            clr_reg      <= clr_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        src_reg  <= src_next;
        dst_reg  <= dst_next;
        fill_reg <= fill_next;
        cur_reg  <= cur_next;
        hop_reg  <= hop_next;
        e_reg    <= e_next;
        end_reg  <= end_next;
        nb_reg   <= nb_next;
    end

    // Edge destinations.
    bhd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    // First edge index of each row.
    bhd_ram #(.WIDTH(ETW), .DEPTH(MAX_NODES + 1)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    // Visited flag and hop count per node.
    bhd_ram #(.WIDTH(VW), .DEPTH(MAX_NODES)) u_vis_ram (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    // Walk queue.
    bhd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    bhd_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .room      (room),
        .rsp       (rsp)
    );

    // The walk queue pointers stay ordered and within the node store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= tail_reg) && (tail_reg <= NIW'(MAX_NODES)))
        else $error("walk queue pointers out of order");

    // The edge count never passes the edge store depth.
    assert property (@(posedge clk) disable iff (!rst_n) et_reg <= ETW'(MAX_EDGES))
        else $error("edge count beyond store");

    // An in-range run starts with the hop store sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.mode == MODE_RUN) && node_ok) |=> (state_reg == ST_CLR))
        else $error("run did not start the sweep");

    // Row fill never runs past the new source.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (fill_reg <= src_reg))
        else $error("row fill passed its source");

endmodule
